// File: rtl/tcw_pkg.sv
// Shared types, codes and constants of the text console writer.
`default_nettype none

package tcw_pkg;

    // default screen geometry
    localparam int COLUMNS_DEFAULT = 80;
    localparam int ROWS_DEFAULT    = 25;

    // fixed payload widths
    localparam int ACTION_W = 2;
    localparam int BYTE_W   = 8;
    localparam int ADDR_W   = 11;
    localparam int CROW_W   = 5;
    localparam int CCOL_W   = 7;
    localparam int CELL_DW  = 2 * BYTE_W;

    localparam logic [BYTE_W-1:0] NEWLINE_CHAR = 8'd10;
    localparam logic [BYTE_W-1:0] SPACE_CHAR   = 8'd32;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUT   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_READ  = 2'd2
    } t_action;

    // write data source of the screen store
    typedef enum logic [1:0] {
        WSEL_ZERO  = 2'd0,
        WSEL_CHAR  = 2'd1,
        WSEL_COPY  = 2'd2,
        WSEL_BLANK = 2'd3
    } t_wsel;

    typedef enum logic [2:0] {
        CUR_HOLD     = 3'd0,
        CUR_ADV      = 3'd1,
        CUR_NEWLINE  = 3'd2,
        CUR_LAST_ROW = 3'd3,
        CUR_HOME     = 3'd4
    } t_cur_op;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [BYTE_W-1:0]   character;
        logic [BYTE_W-1:0]   color;
        logic [ADDR_W-1:0]   cell_address;
    } t_item;

    typedef struct packed {
        logic [CROW_W-1:0] cursor_row;
        logic [CCOL_W-1:0] cursor_col;
        logic [BYTE_W-1:0] cell_char;
        logic [BYTE_W-1:0] cell_color;
    } t_result;

    // controller -> datapath
    typedef struct packed {
        logic    capture;
        logic    mem_we;
        t_wsel   wsel;
        logic    waddr_ptr;   // 1: sweep pointer, 0: cursor cell
        logic    mem_re;
        logic    raddr_ptr;   // 1: pointer plus one row, 0: item address
        logic    ptr_clr;
        logic    ptr_inc;
        t_cur_op cur_op;
        logic    out_load;
        logic    out_cell;    // 1: result carries the read cell
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                is_newline;
        logic                at_row_end;
        logic                at_last_row;
        logic                ptr_copy_end;
        logic                ptr_end;
        logic                addr_ok;
        logic                out_free;
    } t_status;

endpackage

`default_nettype wire

// File: rtl/tcw_if.sv
// Request and result channel interfaces of the text console writer.
`default_nettype none

interface tcw_req_if;
    logic                              valid;
    logic                              ready;
    logic [tcw_pkg::ACTION_W-1:0]      action;
    logic [tcw_pkg::BYTE_W-1:0]        character;
    logic [tcw_pkg::BYTE_W-1:0]        color;
    logic [tcw_pkg::ADDR_W-1:0]        cell_address;

    modport source (output valid, action, character, color, cell_address, input ready);
    modport sink   (input valid, action, character, color, cell_address, output ready);
endinterface

interface tcw_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [tcw_pkg::CROW_W-1:0]        cursor_row;
    logic [tcw_pkg::CCOL_W-1:0]        cursor_col;
    logic [tcw_pkg::BYTE_W-1:0]        cell_char;
    logic [tcw_pkg::BYTE_W-1:0]        cell_color;

    modport source (output valid, cursor_row, cursor_col, cell_char, cell_color, input ready);
    modport sink   (input valid, cursor_row, cursor_col, cell_char, cell_color, output ready);
endinterface

`default_nettype wire

// File: rtl/tcw_datapath.sv
// Datapath: screen store, cursor, sweep pointer, default color and result register.
`default_nettype none

module tcw_datapath #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_wr_en,
    input  wire  [tcw_pkg::BYTE_W-1:0]       i_cfg_wr_data,
    input  wire  tcw_pkg::t_item             i_item,
    input  wire  tcw_pkg::t_cmd              i_cmd,
    output tcw_pkg::t_status                 o_sts,
    output logic                             o_rsp_valid,
    input  wire                              i_rsp_ready,
    output tcw_pkg::t_result                 o_rsp
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int CELL_W     = $clog2(CELL_COUNT);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int AW         = (CELL_W > tcw_pkg::ADDR_W) ? CELL_W : tcw_pkg::ADDR_W;

    localparam logic [CELL_W-1:0] PTR_LAST      = CELL_W'(CELL_COUNT - 1);
    localparam logic [CELL_W-1:0] PTR_COPY_LAST = CELL_W'(CELL_COUNT - COLUMNS - 1);
    localparam logic [CELL_W-1:0] ROW_STEP      = CELL_W'(COLUMNS);
    localparam logic [CELL_W-1:0] LAST_BASE     = CELL_W'((ROWS - 1) * COLUMNS);

    logic [tcw_pkg::CELL_DW-1:0] r_mem [CELL_COUNT];
    logic [tcw_pkg::CELL_DW-1:0] r_rdata;

    logic [tcw_pkg::ACTION_W-1:0] r_action;
    logic [tcw_pkg::BYTE_W-1:0]   r_char;
    logic [tcw_pkg::BYTE_W-1:0]   r_color;
    logic [tcw_pkg::ADDR_W-1:0]   r_addr;
    logic [tcw_pkg::BYTE_W-1:0]   r_default;

    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [CELL_W-1:0] r_base, n_base;
    logic [CELL_W-1:0] r_ptr;

    logic                        r_out_valid;
    tcw_pkg::t_result            r_out;

    logic [tcw_pkg::BYTE_W-1:0]  w_attr;
    logic [CELL_W-1:0]           w_waddr;
    logic [CELL_W-1:0]           w_raddr;
    logic [tcw_pkg::CELL_DW-1:0] w_wdata;
    logic                        w_out_free;

    assign w_attr     = (r_color == '0) ? r_default : r_color;
    assign w_waddr    = i_cmd.waddr_ptr ? r_ptr : (r_base + CELL_W'(r_col));
    assign w_raddr    = i_cmd.raddr_ptr ? (r_ptr + ROW_STEP) : CELL_W'(r_addr);
    assign w_out_free = !r_out_valid || i_rsp_ready;

    always_comb begin
        case (i_cmd.wsel)
            tcw_pkg::WSEL_CHAR:  w_wdata = {w_attr, r_char};
            tcw_pkg::WSEL_COPY:  w_wdata = r_rdata;
            tcw_pkg::WSEL_BLANK: w_wdata = {r_default, tcw_pkg::SPACE_CHAR};
            default:             w_wdata = '0;
        endcase
    end

    // screen store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.mem_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_item.action;
            r_char   <= i_item.character;
            r_color  <= i_item.color;
            r_addr   <= i_item.cell_address;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default <= 8'h0F;
        end else if (i_cfg_wr_en) begin
            r_default <= i_cfg_wr_data;
        end
    end

    // next cursor; a wrap past the last row never reaches CUR_ADV or CUR_NEWLINE
    always_comb begin
        n_row  = r_row;
        n_col  = r_col;
        n_base = r_base;
        case (i_cmd.cur_op)
            tcw_pkg::CUR_ADV: begin
                if (o_sts.at_row_end) begin
                    n_col  = '0;
                    n_row  = r_row + 1'b1;
                    n_base = r_base + ROW_STEP;
                end else begin
                    n_col  = r_col + 1'b1;
                end
            end
            tcw_pkg::CUR_NEWLINE: begin
                n_col  = '0;
                n_row  = r_row + 1'b1;
                n_base = r_base + ROW_STEP;
            end
            tcw_pkg::CUR_LAST_ROW: begin
                n_col  = '0;
                n_row  = ROW_W'(ROWS - 1);
                n_base = LAST_BASE;
            end
            tcw_pkg::CUR_HOME: begin
                n_col  = '0;
                n_row  = '0;
                n_base = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_base <= '0;
            r_ptr  <= '0;
        end else begin
            r_row  <= n_row;
            r_col  <= n_col;
            r_base <= n_base;
            if (i_cmd.ptr_clr) begin
                r_ptr <= '0;
            end else if (i_cmd.ptr_inc) begin
                r_ptr <= r_ptr + 1'b1;
            end
        end
    end

    // result register, loaded with the cursor as it stands after this edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.cursor_row <= tcw_pkg::CROW_W'(n_row);
            r_out.cursor_col <= tcw_pkg::CCOL_W'(n_col);
            r_out.cell_char  <= i_cmd.out_cell ? r_rdata[tcw_pkg::BYTE_W-1:0] : '0;
            r_out.cell_color <= i_cmd.out_cell ?
                                r_rdata[tcw_pkg::CELL_DW-1:tcw_pkg::BYTE_W] : '0;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    assign o_sts.action       = r_action;
    assign o_sts.is_newline   = (r_char == tcw_pkg::NEWLINE_CHAR);
    assign o_sts.at_row_end   = (r_col == COL_W'(COLUMNS - 1));
    assign o_sts.at_last_row  = (r_row == ROW_W'(ROWS - 1));
    assign o_sts.ptr_copy_end = (r_ptr == PTR_COPY_LAST);
    assign o_sts.ptr_end      = (r_ptr == PTR_LAST);
    assign o_sts.addr_ok      = (AW'(r_addr) < AW'(CELL_COUNT));
    assign o_sts.out_free     = w_out_free;

endmodule

`default_nettype wire

// File: rtl/tcw_ctrl.sv
// Controller: sequences puts, reads, scroll and clear sweeps and the reset clearing pass.
`default_nettype none

module tcw_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_req_valid,
    output logic                o_req_ready,
    input  wire  tcw_pkg::t_status i_sts,
    output tcw_pkg::t_cmd       o_cmd
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_READ_WAIT,
        S_SCROLL_RD,
        S_SCROLL_WR,
        S_ZERO_ROW,
        S_CLEAR,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_ready;
    logic   r_cell, n_cell;

    always_comb begin
        n_state         = r_state;
        n_cell          = r_cell;
        o_cmd           = '0;
        o_cmd.wsel      = tcw_pkg::WSEL_ZERO;
        o_cmd.cur_op    = tcw_pkg::CUR_HOLD;
        case (r_state)
            S_INIT: begin
                o_cmd.mem_we    = 1'b1;
                o_cmd.waddr_ptr = 1'b1;
                o_cmd.ptr_inc   = 1'b1;
                if (i_sts.ptr_end) begin
                    o_cmd.ptr_clr = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_IDLE: begin
                if (r_ready && i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                n_cell = 1'b0;
                case (i_sts.action)
                    tcw_pkg::ACT_PUT: begin
                        if (!i_sts.is_newline) begin
                            o_cmd.mem_we = 1'b1;
                            o_cmd.wsel   = tcw_pkg::WSEL_CHAR;
                        end
                        if (i_sts.at_last_row && (i_sts.is_newline || i_sts.at_row_end)) begin
                            o_cmd.cur_op = tcw_pkg::CUR_LAST_ROW;
                            n_state      = S_SCROLL_RD;
                        end else begin
                            o_cmd.cur_op = i_sts.is_newline ? tcw_pkg::CUR_NEWLINE
                                                            : tcw_pkg::CUR_ADV;
                            o_cmd.out_load = i_sts.out_free;
                            n_state        = i_sts.out_free ? S_IDLE : S_DONE;
                        end
                    end
                    tcw_pkg::ACT_CLEAR: begin
                        o_cmd.cur_op = tcw_pkg::CUR_HOME;
                        n_state      = S_CLEAR;
                    end
                    tcw_pkg::ACT_READ: begin
                        if (i_sts.addr_ok) begin
                            o_cmd.mem_re = 1'b1;
                            n_state      = S_READ_WAIT;
                        end else begin
                            o_cmd.out_load = i_sts.out_free;
                            n_state        = i_sts.out_free ? S_IDLE : S_DONE;
                        end
                    end
                    default: begin
                        o_cmd.out_load = i_sts.out_free;
                        n_state        = i_sts.out_free ? S_IDLE : S_DONE;
                    end
                endcase
            end
            S_READ_WAIT: begin
                n_cell         = 1'b1;
                o_cmd.out_load = i_sts.out_free;
                o_cmd.out_cell = 1'b1;
                n_state        = i_sts.out_free ? S_IDLE : S_DONE;
            end
            S_SCROLL_RD: begin
                o_cmd.mem_re    = 1'b1;
                o_cmd.raddr_ptr = 1'b1;
                n_state         = S_SCROLL_WR;
            end
            S_SCROLL_WR: begin
                o_cmd.mem_we    = 1'b1;
                o_cmd.waddr_ptr = 1'b1;
                o_cmd.wsel      = tcw_pkg::WSEL_COPY;
                o_cmd.ptr_inc   = 1'b1;
                n_state         = i_sts.ptr_copy_end ? S_ZERO_ROW : S_SCROLL_RD;
            end
            S_CLEAR: begin
                o_cmd.mem_we    = 1'b1;
                o_cmd.waddr_ptr = 1'b1;
                o_cmd.wsel      = tcw_pkg::WSEL_BLANK;
                o_cmd.ptr_inc   = 1'b1;
                if (i_sts.ptr_copy_end) begin
                    n_state = S_ZERO_ROW;
                end
            end
            S_ZERO_ROW: begin
                o_cmd.mem_we    = 1'b1;
                o_cmd.waddr_ptr = 1'b1;
                o_cmd.ptr_inc   = 1'b1;
                if (i_sts.ptr_end) begin
                    o_cmd.ptr_clr = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.out_cell = r_cell;
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_ready <= 1'b0;
            r_cell  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
            r_cell  <= n_cell;
        end
    end

    assign o_req_ready = r_ready;

endmodule

`default_nettype wire

// File: rtl/text_console_writer.sv
// Top level of the text console writer: controller, datapath and channel wiring.
//
// Usage:
//   i_req carries one request: action (put, clear, read), character, color and
//   cell_address. o_rsp returns one result per request: the cursor row and
//   column after the request, and for a read the character and color of the
//   cell (zero otherwise, and zero for a read beyond the screen).
//   i_cfg_wr_en / i_cfg_wr_data write the default color (reset 0x0F).
// Sequencing (request accept to result valid):
//   put without scroll, unused action, read beyond the screen: the result is
//   loaded from the execute state. Read: the cell is read into a register,
//   then the result is loaded. Put that scrolls: each row below the first is
//   copied up one row (a read, then a write per cell), then the last row is
//   zeroed. Clear: every row but the last is blanked, then the last row is
//   zeroed. A new request is taken only after the previous one has finished.
// Reset: a clearing pass zeroes the store; i_req.ready stays low until it
//   ends. Config writes are also taken during the clearing pass.
// Receiver stall: the result is held in an output register; one more request
//   is accepted and processed, and its result waits until the register frees.
`default_nettype none

module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_wr_en,
    input  wire  [tcw_pkg::BYTE_W-1:0]  i_cfg_wr_data,
    tcw_req_if.sink                     i_req,
    tcw_rsp_if.source                   o_rsp
);

    tcw_pkg::t_cmd    w_cmd;
    tcw_pkg::t_status w_sts;
    tcw_pkg::t_item   w_item;
    tcw_pkg::t_result w_rsp;
    logic             w_req_ready;
    logic             w_rsp_valid;

    // request payload bundled for the datapath capture register
    assign w_item.action       = i_req.action;
    assign w_item.character    = i_req.character;
    assign w_item.color        = i_req.color;
    assign w_item.cell_address = i_req.cell_address;

    assign i_req.ready = w_req_ready;

    tcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_item        (w_item),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_rsp_valid   (w_rsp_valid),
        .i_rsp_ready   (o_rsp.ready),
        .o_rsp         (w_rsp)
    );

    // result register drives the result channel directly
    assign o_rsp.valid      = w_rsp_valid;
    assign o_rsp.cursor_row = w_rsp.cursor_row;
    assign o_rsp.cursor_col = w_rsp.cursor_col;
    assign o_rsp.cell_char  = w_rsp.cell_char;
    assign o_rsp.cell_color = w_rsp.cell_color;

endmodule

`default_nettype wire
